// ===== rtl/core/bpa_pkg.sv =====
// Shared types and constants of the buddy page allocator.
// Used by bpa_ctrl, bpa_dp and buddy_page_allocator; depends on nothing.
package bpa_pkg;

    // Field widths of the stream payloads.
    localparam int SIZE_W      = 32;
    localparam int PAGE_W      = 10;
    localparam int STATUS_W    = 2;
    localparam int ORDER_W     = 4;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 16;

    // Request kinds.
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_BLOCK = 2'd1;
    localparam logic [STATUS_W-1:0] ST_USED     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DOUBLE   = 2'd3;

    // Datapath operations issued by the controller.
    localparam int OPW = 5;
    localparam logic [OPW-1:0] OP_NONE       = 5'd0;
    localparam logic [OPW-1:0] OP_CLR        = 5'd1;
    localparam logic [OPW-1:0] OP_LOAD       = 5'd2;
    localparam logic [OPW-1:0] OP_K_ORDER    = 5'd3;
    localparam logic [OPW-1:0] OP_K_INC      = 5'd4;
    localparam logic [OPW-1:0] OP_RD_FRONT   = 5'd5;
    localparam logic [OPW-1:0] OP_SPLIT_POP  = 5'd6;
    localparam logic [OPW-1:0] OP_PUSH_B     = 5'd7;
    localparam logic [OPW-1:0] OP_PUSH_BUDDY = 5'd8;
    localparam logic [OPW-1:0] OP_TAKE_CHK   = 5'd9;
    localparam logic [OPW-1:0] OP_TAKE       = 5'd10;
    localparam logic [OPW-1:0] OP_MARK       = 5'd11;
    localparam logic [OPW-1:0] OP_RD_USED    = 5'd12;
    localparam logic [OPW-1:0] OP_F_INIT     = 5'd13;
    localparam logic [OPW-1:0] OP_PUSH_P     = 5'd14;
    localparam logic [OPW-1:0] OP_FIND_INIT  = 5'd15;
    localparam logic [OPW-1:0] OP_RD_AT      = 5'd16;
    localparam logic [OPW-1:0] OP_I_INC      = 5'd17;
    localparam logic [OPW-1:0] OP_RD_NEXT    = 5'd18;
    localparam logic [OPW-1:0] OP_WR_AT      = 5'd19;
    localparam logic [OPW-1:0] OP_ERASE_FIN  = 5'd20;
    localparam logic [OPW-1:0] OP_SET_ST     = 5'd21;
    localparam logic [OPW-1:0] OP_EMIT       = 5'd22;

    typedef struct packed {
        logic [OPW-1:0]      op;
        logic [STATUS_W-1:0] st;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic req_free;
        logic cnt_zero;
        logic k_gt_max;
        logic k_ge_max;
        logic k_eq_order;
        logic used_hit;
        logic i_end;
        logic hit;
        logic e_end;
        logic mark_last;
        logic out_free;
    } t_flags;

endpackage

// ===== rtl/core/bpa_ctrl.sv =====
// Sequencer of the buddy page allocator: one state machine issuing datapath operations.
// Depends on bpa_pkg for the command and flag structs and operation codes.
module bpa_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  bpa_pkg::t_flags i_flags,
    output bpa_pkg::t_cmd   o_cmd
);

    localparam logic [4:0] S_CLR     = 5'd0;
    localparam logic [4:0] S_IDLE    = 5'd1;
    localparam logic [4:0] S_DISP    = 5'd2;
    localparam logic [4:0] S_A1      = 5'd3;
    localparam logic [4:0] S_SCAN    = 5'd4;
    localparam logic [4:0] S_SPL_RD  = 5'd5;
    localparam logic [4:0] S_SPL_POP = 5'd6;
    localparam logic [4:0] S_PUSH_LO = 5'd7;
    localparam logic [4:0] S_PUSH_HI = 5'd8;
    localparam logic [4:0] S_TAKE0   = 5'd9;
    localparam logic [4:0] S_TAKE1   = 5'd10;
    localparam logic [4:0] S_TAKE2   = 5'd11;
    localparam logic [4:0] S_MARK    = 5'd12;
    localparam logic [4:0] S_F1      = 5'd13;
    localparam logic [4:0] S_F2      = 5'd14;
    localparam logic [4:0] S_F3      = 5'd15;
    localparam logic [4:0] S_F4      = 5'd16;
    localparam logic [4:0] S_E0      = 5'd17;
    localparam logic [4:0] S_E1      = 5'd18;
    localparam logic [4:0] S_DONE    = 5'd19;

    logic [4:0] r_state;
    logic [4:0] n_state;

    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        o_cmd.op = bpa_pkg::OP_NONE;
        o_cmd.st = bpa_pkg::ST_OK;
        case (r_state)
            S_CLR: begin
                o_cmd.op = bpa_pkg::OP_CLR;
                if (i_flags.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.op = bpa_pkg::OP_LOAD;
                    n_state  = S_DISP;
                end
            end
            S_DISP: begin
                if (i_flags.req_free) begin
                    o_cmd.op = bpa_pkg::OP_RD_USED;
                    n_state  = S_F1;
                end else begin
                    o_cmd.op = bpa_pkg::OP_K_ORDER;
                    n_state  = S_A1;
                end
            end
            S_A1: begin
                if (i_flags.cnt_zero) begin
                    o_cmd.op = bpa_pkg::OP_K_INC;
                    n_state  = S_SCAN;
                end else begin
                    n_state = S_TAKE0;
                end
            end
            S_SCAN: begin
                if (i_flags.k_gt_max) begin
                    o_cmd.op = bpa_pkg::OP_SET_ST;
                    o_cmd.st = bpa_pkg::ST_NO_BLOCK;
                    n_state  = S_DONE;
                end else if (i_flags.cnt_zero) begin
                    o_cmd.op = bpa_pkg::OP_K_INC;
                end else begin
                    o_cmd.op = bpa_pkg::OP_RD_FRONT;
                    n_state  = S_SPL_POP;
                end
            end
            S_SPL_RD: begin
                o_cmd.op = bpa_pkg::OP_RD_FRONT;
                n_state  = S_SPL_POP;
            end
            S_SPL_POP: begin
                o_cmd.op = bpa_pkg::OP_SPLIT_POP;
                n_state  = S_PUSH_LO;
            end
            S_PUSH_LO: begin
                o_cmd.op = bpa_pkg::OP_PUSH_B;
                n_state  = S_PUSH_HI;
            end
            S_PUSH_HI: begin
                o_cmd.op = bpa_pkg::OP_PUSH_BUDDY;
                n_state  = i_flags.k_eq_order ? S_TAKE0 : S_SPL_RD;
            end
            S_TAKE0: begin
                if (i_flags.cnt_zero) begin
                    o_cmd.op = bpa_pkg::OP_SET_ST;
                    o_cmd.st = bpa_pkg::ST_NO_BLOCK;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = bpa_pkg::OP_RD_FRONT;
                    n_state  = S_TAKE1;
                end
            end
            S_TAKE1: begin
                o_cmd.op = bpa_pkg::OP_TAKE_CHK;
                n_state  = S_TAKE2;
            end
            S_TAKE2: begin
                if (i_flags.used_hit) begin
                    o_cmd.op = bpa_pkg::OP_SET_ST;
                    o_cmd.st = bpa_pkg::ST_USED;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = bpa_pkg::OP_TAKE;
                    n_state  = S_MARK;
                end
            end
            S_MARK: begin
                o_cmd.op = bpa_pkg::OP_MARK;
                if (i_flags.mark_last) n_state = S_DONE;
            end
            S_F1: begin
                if (!i_flags.used_hit) begin
                    o_cmd.op = bpa_pkg::OP_SET_ST;
                    o_cmd.st = bpa_pkg::ST_DOUBLE;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = bpa_pkg::OP_F_INIT;
                    n_state  = S_F2;
                end
            end
            S_F2: begin
                if (i_flags.k_ge_max) begin
                    o_cmd.op = bpa_pkg::OP_PUSH_P;
                    n_state  = S_MARK;
                end else begin
                    o_cmd.op = bpa_pkg::OP_FIND_INIT;
                    n_state  = S_F3;
                end
            end
            S_F3: begin
                if (i_flags.i_end) begin
                    o_cmd.op = bpa_pkg::OP_PUSH_P;
                    n_state  = S_MARK;
                end else begin
                    o_cmd.op = bpa_pkg::OP_RD_AT;
                    n_state  = S_F4;
                end
            end
            S_F4: begin
                if (i_flags.hit) begin
                    n_state = S_E0;
                end else begin
                    o_cmd.op = bpa_pkg::OP_I_INC;
                    n_state  = S_F3;
                end
            end
            S_E0: begin
                if (i_flags.e_end) begin
                    o_cmd.op = bpa_pkg::OP_ERASE_FIN;
                    n_state  = S_F2;
                end else begin
                    o_cmd.op = bpa_pkg::OP_RD_NEXT;
                    n_state  = S_E1;
                end
            end
            S_E1: begin
                o_cmd.op = bpa_pkg::OP_WR_AT;
                n_state  = S_E0;
            end
            S_DONE: begin
                if (i_flags.out_free) begin
                    o_cmd.op = bpa_pkg::OP_EMIT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/core/bpa_dp.sv =====
// Datapath of the buddy page allocator: free-list memory, page used bitmap,
// list heads and counts, work registers and the result register. Depends on bpa_pkg.
module bpa_dp #(
    parameter int POOL_PAGES = 1024,
    parameter int TOP_ORDER  = 10,
    parameter int PAGE_BYTES = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  bpa_pkg::t_cmd                       i_cmd,
    output bpa_pkg::t_flags                     o_flags,
    input  logic [bpa_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    input  logic                                i_s_tuser,
    input  logic                                i_m_tready,
    output logic                                o_m_tvalid,
    output logic [bpa_pkg::OUT_TDATA_W-1:0]     o_m_tdata,
    output logic [bpa_pkg::STATUS_W-1:0]        o_m_tuser
);

    localparam int NL  = TOP_ORDER + 1;
    localparam int LW  = $clog2(NL);
    localparam int KW  = $clog2(NL + 1);
    localparam int HW  = $clog2(POOL_PAGES);
    localparam int CW  = $clog2(POOL_PAGES + 1);
    localparam int PW0 = (HW > TOP_ORDER) ? HW : TOP_ORDER;
    localparam int PW  = (PW0 > bpa_pkg::PAGE_W) ? PW0 : bpa_pkg::PAGE_W;
    localparam int IW  = (CW > TOP_ORDER) ? CW : TOP_ORDER;
    localparam int SW  = ((PW > IW) ? PW : IW) + 1;
    localparam int MD  = NL * (2 ** HW);

    // Position head + offset within a circular list of POOL_PAGES entries.
    function automatic logic [HW-1:0] f_wrap(input logic [HW-1:0] h, input logic [CW-1:0] o);
        logic [HW:0] s;
        s = {1'b0, h} + (HW+1)'(o);
        if (s >= (HW+1)'(POOL_PAGES)) s = s - (HW+1)'(POOL_PAGES);
        return s[HW-1:0];
    endfunction

    // Ceiling log2 of the page count, capped at TOP_ORDER, found by comparing against block sizes in bytes.
    function automatic logic [KW-1:0] f_order(input logic [bpa_pkg::SIZE_W-1:0] sz);
        logic [KW-1:0] n;
        n = '0;
        for (int k = 0; k < TOP_ORDER; k++) begin
            if (64'(sz) > (64'(PAGE_BYTES) << k)) n = n + KW'(1);
        end
        return n;
    endfunction

    logic [PW-1:0] r_list_mem [MD];
    logic          r_used_mem [POOL_PAGES];

    logic [HW-1:0] r_head [NL];
    logic [CW-1:0] r_cnt  [NL];
    logic [IW-1:0] r_i;
    logic          r_out_valid;

    logic                        r_req;
    logic [KW-1:0]               r_order;
    logic [PW-1:0]               r_page;
    logic [KW-1:0]               r_k;
    logic [PW-1:0]               r_p;
    logic [PW-1:0]               r_b;
    logic                        r_mark;
    logic [bpa_pkg::STATUS_W-1:0] r_status;
    logic [PW-1:0]               r_block;
    logic [PW-1:0]               r_rd_data;
    logic                        r_used_q;
    logic                        r_rd_ok;
    logic [bpa_pkg::OUT_TDATA_W-1:0] r_out_tdata;
    logic [bpa_pkg::STATUS_W-1:0]    r_out_tuser;

    logic [LW-1:0] ki;
    logic [HW-1:0] cur_head;
    logic [CW-1:0] cur_cnt;
    logic          cnt_full;
    logic [PW-1:0] buddy;
    logic [IW-1:0] mark_mask;
    logic [SW-1:0] mark_addr;

    logic                 lw_en;
    logic [LW+HW-1:0]     lw_addr;
    logic [PW-1:0]        lw_data;
    logic                 lr_en;
    logic [LW+HW-1:0]     lr_addr;
    logic                 uw_en;
    logic [HW-1:0]        uw_addr;
    logic                 uw_data;
    logic                 ur_en;
    logic [PW-1:0]        ur_page;

    assign ki        = r_k[LW-1:0];
    assign cur_head  = r_head[ki];
    assign cur_cnt   = r_cnt[ki];
    assign cnt_full  = (cur_cnt >= CW'(POOL_PAGES));
    assign buddy     = r_p ^ (PW'(1) << r_k);
    assign mark_mask = (IW'(1) << r_k) - IW'(1);
    assign mark_addr = SW'(r_p) + SW'(r_i);

    always_comb begin
        o_flags.clr_last   = (r_i == IW'(POOL_PAGES - 1));
        o_flags.req_free   = (r_req == bpa_pkg::REQ_FREE);
        o_flags.cnt_zero   = (cur_cnt == '0);
        o_flags.k_gt_max   = (r_k > KW'(TOP_ORDER));
        o_flags.k_ge_max   = (r_k >= KW'(TOP_ORDER));
        o_flags.k_eq_order = (r_k == r_order);
        o_flags.used_hit   = r_used_q && r_rd_ok;
        o_flags.i_end      = (r_i >= IW'(cur_cnt));
        o_flags.hit        = (r_rd_data == buddy);
        o_flags.e_end      = ((r_i + IW'(1)) >= IW'(cur_cnt));
        o_flags.mark_last  = (r_i == mark_mask);
        o_flags.out_free   = !r_out_valid || i_m_tready;
    end

    // Free-list memory port selection.
    always_comb begin
        lw_en   = 1'b0;
        lw_addr = {ki, f_wrap(cur_head, cur_cnt)};
        lw_data = r_p;
        lr_en   = 1'b0;
        lr_addr = {ki, cur_head};
        case (i_cmd.op)
            bpa_pkg::OP_CLR: begin
                // The pool starts as one top-order block at page zero.
                lw_en   = (r_i == '0);
                lw_addr = {LW'(TOP_ORDER), HW'(0)};
                lw_data = '0;
            end
            bpa_pkg::OP_PUSH_B: begin
                lw_en   = !cnt_full;
                lw_data = r_b;
            end
            bpa_pkg::OP_PUSH_BUDDY: begin
                lw_en   = !cnt_full;
                lw_data = r_b ^ (PW'(1) << r_k);
            end
            bpa_pkg::OP_PUSH_P: begin
                lw_en = !cnt_full;
            end
            bpa_pkg::OP_WR_AT: begin
                lw_en   = 1'b1;
                lw_addr = {ki, f_wrap(cur_head, CW'(r_i))};
                lw_data = r_rd_data;
            end
            bpa_pkg::OP_RD_FRONT: begin
                lr_en = 1'b1;
            end
            bpa_pkg::OP_RD_AT: begin
                lr_en   = 1'b1;
                lr_addr = {ki, f_wrap(cur_head, CW'(r_i))};
            end
            bpa_pkg::OP_RD_NEXT: begin
                lr_en   = 1'b1;
                lr_addr = {ki, f_wrap(cur_head, CW'(r_i + IW'(1)))};
            end
            default: begin
            end
        endcase
    end

    // Used bitmap port selection.
    always_comb begin
        uw_en   = 1'b0;
        uw_addr = r_i[HW-1:0];
        uw_data = 1'b0;
        ur_en   = 1'b0;
        ur_page = r_page;
        case (i_cmd.op)
            bpa_pkg::OP_CLR: begin
                uw_en = 1'b1;
            end
            bpa_pkg::OP_MARK: begin
                uw_en   = (mark_addr < SW'(POOL_PAGES));
                uw_addr = mark_addr[HW-1:0];
                uw_data = r_mark;
            end
            bpa_pkg::OP_TAKE_CHK: begin
                ur_en   = 1'b1;
                ur_page = r_rd_data;
            end
            bpa_pkg::OP_RD_USED: begin
                ur_en = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (lw_en) r_list_mem[lw_addr] <= lw_data;
        if (lr_en) r_rd_data <= r_list_mem[lr_addr];
    end

    always_ff @(posedge i_clk) begin
        if (uw_en) r_used_mem[uw_addr] <= uw_data;
        if (ur_en) begin
            r_used_q <= r_used_mem[ur_page[HW-1:0]];
            r_rd_ok  <= ({1'b0, ur_page} < (PW+1)'(POOL_PAGES));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < NL; l++) begin
                r_head[l] <= '0;
                r_cnt[l]  <= (l == TOP_ORDER) ? CW'(1) : '0;
            end
            r_i         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == bpa_pkg::OP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd.op)
                bpa_pkg::OP_CLR: begin
                    r_i <= o_flags.clr_last ? '0 : r_i + IW'(1);
                end
                bpa_pkg::OP_SPLIT_POP: begin
                    if (cur_cnt != '0) begin
                        r_head[ki] <= f_wrap(cur_head, CW'(1));
                        r_cnt[ki]  <= cur_cnt - CW'(1);
                    end
                end
                bpa_pkg::OP_TAKE: begin
                    if (cur_cnt != '0) begin
                        r_head[ki] <= f_wrap(cur_head, CW'(1));
                        r_cnt[ki]  <= cur_cnt - CW'(1);
                    end
                    r_i <= '0;
                end
                bpa_pkg::OP_PUSH_B, bpa_pkg::OP_PUSH_BUDDY: begin
                    if (!cnt_full) r_cnt[ki] <= cur_cnt + CW'(1);
                end
                bpa_pkg::OP_PUSH_P: begin
                    if (!cnt_full) r_cnt[ki] <= cur_cnt + CW'(1);
                    r_i <= '0;
                end
                bpa_pkg::OP_FIND_INIT: begin
                    r_i <= '0;
                end
                bpa_pkg::OP_MARK, bpa_pkg::OP_I_INC, bpa_pkg::OP_WR_AT: begin
                    r_i <= r_i + IW'(1);
                end
                bpa_pkg::OP_ERASE_FIN: begin
                    r_cnt[ki] <= cur_cnt - CW'(1);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            bpa_pkg::OP_LOAD: begin
                r_req    <= i_s_tuser;
                r_order  <= f_order(i_s_tdata[bpa_pkg::SIZE_W-1:0]);
                r_page   <= PW'(i_s_tdata[bpa_pkg::SIZE_W +: bpa_pkg::PAGE_W]);
                r_status <= bpa_pkg::ST_OK;
                r_block  <= '0;
            end
            bpa_pkg::OP_K_ORDER: r_k <= r_order;
            bpa_pkg::OP_K_INC:   r_k <= r_k + KW'(1);
            bpa_pkg::OP_SPLIT_POP: begin
                r_b <= r_rd_data;
                r_k <= r_k - KW'(1);
            end
            bpa_pkg::OP_TAKE_CHK: r_b <= r_rd_data;
            bpa_pkg::OP_TAKE: begin
                r_block <= r_b;
                r_p     <= r_b;
                r_mark  <= 1'b1;
            end
            bpa_pkg::OP_F_INIT: begin
                r_k <= r_order;
                r_p <= r_page;
            end
            bpa_pkg::OP_PUSH_P: r_mark <= 1'b0;
            bpa_pkg::OP_ERASE_FIN: begin
                // The merged block starts at the lower of the two buddies.
                if (buddy < r_p) r_p <= buddy;
                r_k <= r_k + KW'(1);
            end
            bpa_pkg::OP_SET_ST: r_status <= i_cmd.st;
            bpa_pkg::OP_EMIT: begin
                r_out_tdata <= {{(bpa_pkg::OUT_TDATA_W - bpa_pkg::ORDER_W - bpa_pkg::PAGE_W){1'b0}},
                                r_order[bpa_pkg::ORDER_W-1:0], r_block[bpa_pkg::PAGE_W-1:0]};
                r_out_tuser <= r_status;
            end
            default: begin
            end
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_tdata;
    assign o_m_tuser  = r_out_tuser;

endmodule

// ===== rtl/core/buddy_page_allocator.sv =====
// Buddy page allocator over POOL_PAGES pages of PAGE_BYTES bytes, orders 0 to TOP_ORDER,
// one request at a time. Each transfer in returns exactly one result transfer. After reset
// a clearing pass runs over the page bitmap before the first request is taken. Each request
// walks the list memory and the bitmap in steps: an allocate scans past empty orders,
// splits one level at a time down to its order and marks the block's pages used; a free
// searches the list of each merge level for the buddy, shifts the later entries down on
// removal, and marks the final block free. A double free, an allocate that finds no block
// and one that meets a used front block finish early; a stalled result side holds back
// every result.
// Depends on bpa_pkg, bpa_ctrl and bpa_dp.
module buddy_page_allocator #(
    parameter int POOL_PAGES = 1024,
    parameter int TOP_ORDER  = 10,
    parameter int PAGE_BYTES = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // size_bytes [31:0], page_index [41:32], zero [47:42]
    input  logic [bpa_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    // req_type [0]
    input  logic                                i_s_tuser,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // block_page [9:0], block_order [13:10], zero [15:14]
    output logic [bpa_pkg::OUT_TDATA_W-1:0]     o_m_tdata,
    // status [1:0]
    output logic [bpa_pkg::STATUS_W-1:0]        o_m_tuser
);

    bpa_pkg::t_cmd   w_cmd;
    bpa_pkg::t_flags w_flags;

    bpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_flags    (w_flags),
        .o_cmd      (w_cmd)
    );

    bpa_dp #(
        .POOL_PAGES (POOL_PAGES),
        .TOP_ORDER  (TOP_ORDER),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_flags    (w_flags),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

`ifndef ASSERT_OFF
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("second request taken while one is in progress");

    a_load_on_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.op == bpa_pkg::OP_LOAD) |-> (i_s_tvalid && o_s_tready))
        else $error("request loaded without an input transfer");

    a_fail_no_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser != bpa_pkg::ST_OK))
        |-> (o_m_tdata[bpa_pkg::PAGE_W-1:0] == '0))
        else $error("failed request reports a block page");
`endif

endmodule
